/* hw/rtl/jetr_pkg.sv */
// Shared types, constants and helper functions for the rotated Julia escape-time core.
// Used by every module of the block; depends on nothing else.
package jetr_pkg;

    // Frame geometry.
    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 768;

    // Datapath widths.
    localparam int PIX_W      = 10;
    localparam int COORD_W    = 13;   // pixel minus half frame, signed
    localparam int ROT_W      = 16;   // rotated integer coordinate, signed
    localparam int TRIG_W     = 16;   // Q1.14 sine and cosine
    localparam int Q_W        = 32;   // Q4.28 plane values
    localparam int PROD_W     = 64;   // full product of the shared multiplier
    localparam int CNT_W      = 8;
    localparam int MODE_W     = 2;
    localparam int COLOUR_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 28;
    localparam int ROT_FRAC   = 14;

    localparam logic signed [PROD_W-1:0] HALF_WIDTH = PROD_W'(FRAME_WIDTH / 2);
    localparam logic signed [COORD_W-1:0] HALF_WIDTH_C = COORD_W'(FRAME_WIDTH / 2);
    localparam logic signed [COORD_W-1:0] HALF_HEIGHT_C = COORD_W'(FRAME_HEIGHT / 2);
    localparam logic signed [PROD_W-1:0] ROW_BIAS =
        PROD_W'((FRAME_HEIGHT / 2) * (1 << ROT_FRAC));
    localparam logic signed [PROD_W-1:0] ROT_ROUND = PROD_W'((1 << ROT_FRAC) - 1);

    // Julia constant c = 0.4585 + 0.4585i and squared bailout radius, Q4.28 / Q8.56.
    localparam logic signed [PROD_W-1:0] C_CONST = 64'sd123077657;
    localparam logic [PROD_W-1:0] BAIL_Q56 = 64'd563489559 << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] Q_MIN = -64'sd2147483648;

    localparam int COLOUR_SCALE = 20;
    localparam int SCALED_W     = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_SINE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_COSINE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE     = 3'd7;

    // Color lane codes.
    localparam logic [MODE_W-1:0] MODE_BLUE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GREEN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RED   = 2'd2;

    // Register values after reset.
    localparam logic [TRIG_W-1:0]  RST_SINE      = 16'd0;
    localparam logic [TRIG_W-1:0]  RST_COSINE    = 16'd16384;
    localparam logic [Q_W-1:0]     RST_STEP_RE   = 32'd524801;
    localparam logic [Q_W-1:0]     RST_STEP_IM   = 32'd699962;
    localparam logic [Q_W-1:0]     RST_ORIGIN_RE = 32'hF18D_2E52;
    localparam logic [Q_W-1:0]     RST_ORIGIN_IM = 32'd44800267;
    localparam logic [CNT_W-1:0]   RST_LIMIT     = 8'd200;
    localparam logic [MODE_W-1:0]  RST_MODE      = MODE_BLUE;

    // Operand pairs for the shared multiplier.
    typedef enum logic [3:0] {
        MUL_DX_COS,
        MUL_DY_SIN,
        MUL_DX_SIN,
        MUL_DY_COS,
        MUL_RX_STEP,
        MUL_RY_STEP,
        MUL_ZR_ZR,
        MUL_ZI_ZI,
        MUL_ZR_ZI
    } t_mul_op;

    typedef struct packed {
        t_mul_op op;
        logic    ld_pix;
        logic    ld_sr;
        logic    ld_rx;
        logic    ld_ry;
        logic    ld_zr_map;
        logic    ld_zi_map;
        logic    ld_zr_iter;
        logic    ld_zi_iter;
    } t_dp_ctrl;

    typedef struct packed {
        logic [TRIG_W-1:0] sine;
        logic [TRIG_W-1:0] cosine;
        logic [Q_W-1:0]    step_re;
        logic [Q_W-1:0]    step_im;
        logic [Q_W-1:0]    origin_re;
        logic [Q_W-1:0]    origin_im;
        logic [CNT_W-1:0]  limit;
        logic [MODE_W-1:0] mode;
    } t_cfg;

    // Clamp a wide value to the Q4.28 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[Q_W-1:0];
        end else if (v < Q_MIN) begin
            r = Q_MIN[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // Divide by 2^14 with truncation toward zero.
    function automatic logic signed [PROD_W-1:0] trunc_rot(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] b;
        b = v[PROD_W-1] ? (v + ROT_ROUND) : v;
        return b >>> ROT_FRAC;
    endfunction

endpackage

/* hw/rtl/jetr_mul.sv */
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
// Depends on jetr_pkg for widths.
module jetr_mul
    import jetr_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [Q_W-1:0]    i_a,
    input  logic signed [Q_W-1:0]    i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/jetr_dp.sv */
// Datapath: operand selection for the shared multiplier, rotation, plane mapping
// and the z update. Depends on jetr_pkg and jetr_mul.
module jetr_dp
    import jetr_pkg::*;
(
    input  logic             i_clk,
    input  t_dp_ctrl         i_ctrl,
    input  t_cfg             i_cfg,
    input  logic [PIX_W-1:0] i_pixel_column,
    input  logic [PIX_W-1:0] i_pixel_row,
    output logic             o_bail
);

    logic signed [COORD_W-1:0] r_dx;
    logic signed [COORD_W-1:0] r_dy;
    logic signed [ROT_W-1:0]   r_rx;
    logic signed [ROT_W-1:0]   r_ry;
    logic signed [PROD_W-1:0]  r_sr;
    logic signed [Q_W-1:0]     r_zr;
    logic signed [Q_W-1:0]     r_zi;

    logic signed [Q_W-1:0]     w_a;
    logic signed [Q_W-1:0]     w_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_rot_x;
    logic signed [PROD_W-1:0]  w_rot_y;
    logic signed [Q_W-1:0]     w_zr_map;
    logic signed [Q_W-1:0]     w_zi_map;
    logic signed [Q_W-1:0]     w_zr_iter;
    logic signed [Q_W-1:0]     w_zi_iter;
    logic [PROD_W-1:0]         w_mag;

    always_comb begin
        w_a = r_zr;
        w_b = r_zr;
        case (i_ctrl.op)
            MUL_DX_COS: begin
                w_a = Q_W'(r_dx);
                w_b = Q_W'($signed(i_cfg.cosine));
            end
            MUL_DY_SIN: begin
                w_a = Q_W'(r_dy);
                w_b = Q_W'($signed(i_cfg.sine));
            end
            MUL_DX_SIN: begin
                w_a = Q_W'(r_dx);
                w_b = Q_W'($signed(i_cfg.sine));
            end
            MUL_DY_COS: begin
                w_a = Q_W'(r_dy);
                w_b = Q_W'($signed(i_cfg.cosine));
            end
            MUL_RX_STEP: begin
                w_a = Q_W'(r_rx);
                w_b = $signed(i_cfg.step_re);
            end
            MUL_RY_STEP: begin
                w_a = Q_W'(r_ry);
                w_b = $signed(i_cfg.step_im);
            end
            MUL_ZR_ZR: begin
                w_a = r_zr;
                w_b = r_zr;
            end
            MUL_ZI_ZI: begin
                w_a = r_zi;
                w_b = r_zi;
            end
            MUL_ZR_ZI: begin
                w_a = r_zr;
                w_b = r_zi;
            end
            default: begin
                w_a = r_zr;
                w_b = r_zr;
            end
        endcase
    end

    jetr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // Rotation: r_sr holds the first product, w_prod the second.
    assign w_rot_x = trunc_rot(r_sr - w_prod) + HALF_WIDTH;
    assign w_rot_y = trunc_rot(r_sr + w_prod + ROW_BIAS);

    assign w_zr_map = sat_q(w_prod + PROD_W'($signed(i_cfg.origin_re)));
    assign w_zi_map = sat_q(w_prod + PROD_W'($signed(i_cfg.origin_im)));

    // z update: r_sr is zr^2, w_prod is zi^2 (real part) or zr*zi (imaginary part).
    assign w_zr_iter = sat_q(((r_sr - w_prod) >>> FRAC_BITS) + C_CONST);
    assign w_zi_iter = sat_q((w_prod >>> (FRAC_BITS - 1)) + C_CONST);

    // Both squares are non-negative and at most 2^62, so the sum cannot wrap.
    assign w_mag  = $unsigned(r_sr) + $unsigned(w_prod);
    assign o_bail = (w_mag >= BAIL_Q56);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_pix) begin
            r_dx <= $signed({{(COORD_W-PIX_W){1'b0}}, i_pixel_column}) - HALF_WIDTH_C;
            r_dy <= $signed({{(COORD_W-PIX_W){1'b0}}, i_pixel_row}) - HALF_HEIGHT_C;
        end
        if (i_ctrl.ld_sr) begin
            r_sr <= w_prod;
        end
        if (i_ctrl.ld_rx) begin
            r_rx <= w_rot_x[ROT_W-1:0];
        end
        if (i_ctrl.ld_ry) begin
            r_ry <= w_rot_y[ROT_W-1:0];
        end
        if (i_ctrl.ld_zr_map) begin
            r_zr <= w_zr_map;
        end else if (i_ctrl.ld_zr_iter) begin
            r_zr <= w_zr_iter;
        end
        if (i_ctrl.ld_zi_map) begin
            r_zi <= w_zi_map;
        end else if (i_ctrl.ld_zi_iter) begin
            r_zi <= w_zi_iter;
        end
    end

endmodule

/* hw/rtl/jetr_seq.sv */
// Sequencer: steps the shared multiplier through rotation, mapping and iteration,
// counts iterations and holds the output register. Depends on jetr_pkg.
module jetr_seq
    import jetr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [CNT_W-1:0]    o_escape_count,
    output logic [COLOUR_W-1:0] o_pixel_colour,
    input  logic                i_bail,
    output t_dp_ctrl            o_ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT_A,
        ST_ROT_B,
        ST_ROT_C,
        ST_ROT_D,
        ST_MAP_A,
        ST_MAP_B,
        ST_MAP_C,
        ST_IT_A,
        ST_IT_B,
        ST_IT_C,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_count;
    logic [COLOUR_W-1:0] r_out_colour;

    logic [CNT_W-1:0]    n_count;
    logic [SCALED_W-1:0] w_scaled;
    logic [COLOUR_W-1:0] w_colour;
    logic                w_out_free;

    assign n_count    = r_count + CNT_W'(1);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_scaled   = SCALED_W'(r_count) * SCALED_W'(COLOUR_SCALE);

    always_comb begin
        case (i_cfg.mode)
            MODE_BLUE:  w_colour = COLOUR_W'(w_scaled);
            MODE_GREEN: w_colour = COLOUR_W'({w_scaled, 8'd0});
            default:    w_colour = COLOUR_W'({w_scaled, 16'd0});
        endcase
    end

    always_comb begin
        o_ctrl    = '0;
        o_ctrl.op = MUL_ZR_ZR;
        case (r_state)
            ST_IDLE: begin
                o_ctrl.ld_pix = i_in_valid;
            end
            ST_ROT_A: begin
                o_ctrl.op = MUL_DX_COS;
            end
            ST_ROT_B: begin
                o_ctrl.op    = MUL_DY_SIN;
                o_ctrl.ld_sr = 1'b1;
            end
            ST_ROT_C: begin
                o_ctrl.op    = MUL_DX_SIN;
                o_ctrl.ld_rx = 1'b1;
            end
            ST_ROT_D: begin
                o_ctrl.op    = MUL_DY_COS;
                o_ctrl.ld_sr = 1'b1;
            end
            ST_MAP_A: begin
                o_ctrl.op    = MUL_RX_STEP;
                o_ctrl.ld_ry = 1'b1;
            end
            ST_MAP_B: begin
                o_ctrl.op        = MUL_RY_STEP;
                o_ctrl.ld_zr_map = 1'b1;
            end
            ST_MAP_C: begin
                o_ctrl.op        = MUL_ZR_ZR;
                o_ctrl.ld_zi_map = 1'b1;
            end
            ST_IT_A: begin
                o_ctrl.op         = MUL_ZR_ZR;
                o_ctrl.ld_zi_iter = 1'b1;
            end
            ST_IT_B: begin
                o_ctrl.op    = MUL_ZI_ZI;
                o_ctrl.ld_sr = 1'b1;
            end
            ST_IT_C: begin
                o_ctrl.op         = MUL_ZR_ZI;
                o_ctrl.ld_zr_iter = !i_bail;
            end
            default: begin
                o_ctrl.op = MUL_ZR_ZR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A finished result refills the output register; otherwise a taken beat empties it.
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_ROT_A;
                    end
                end
                ST_ROT_A: r_state <= ST_ROT_B;
                ST_ROT_B: r_state <= ST_ROT_C;
                ST_ROT_C: r_state <= ST_ROT_D;
                ST_ROT_D: r_state <= ST_MAP_A;
                ST_MAP_A: r_state <= ST_MAP_B;
                ST_MAP_B: r_state <= ST_MAP_C;
                ST_MAP_C: begin
                    r_count <= '0;
                    r_state <= (i_cfg.limit == '0) ? ST_DONE : ST_IT_B;
                end
                ST_IT_A: r_state <= ST_IT_B;
                ST_IT_B: r_state <= ST_IT_C;
                ST_IT_C: begin
                    if (i_bail) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_count <= n_count;
                        r_state <= (n_count == i_cfg.limit) ? ST_DONE : ST_IT_A;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_count  <= r_count;
                        r_out_colour <= w_colour;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_out_count;
    assign o_pixel_colour = r_out_colour;

endmodule

/* hw/rtl/julia_escape_time_rotated_core.sv */
// Top level of the rotated Julia escape-time core: configuration registers,
// sequencer and datapath. Depends on jetr_pkg, jetr_seq, jetr_dp and jetr_mul.
//
// Usage: each input beat carries one pixel position (column, row). The core
// rotates it about the frame center with the configured sine and cosine, maps
// it onto the complex plane with the configured step and origin, and iterates
// z = z*z + c until |z|^2 reaches the squared bailout radius or the iteration
// limit. Each input beat yields exactly one output beat with the iteration
// count and a color word, count*20 starting at the blue, green or red byte lane.
//
// All multiplications run on a single 32x32 multiplier with a registered
// product. Rotation and mapping come first; each iteration then computes
// zr^2, zi^2 and zr*zi in turn, and a zero limit skips the iterations. The
// core takes one pixel at a time: o_in_stall is high from acceptance until
// the result moves into the output register. The next pixel is accepted
// even while the previous result still waits. If the receiver stalls long
// enough, a finished second result waits in the sequencer until the
// register frees.
// Synchronous active-low reset returns the configuration registers to their
// default values, empties the output register and leaves the core ready for
// a new beat. Configuration writes take effect at once, so the user must
// see that they are made only while no pixel is in flight; the core itself
// does not enforce this.
module julia_escape_time_rotated_core
    import jetr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Pixel input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_column,
    input  logic [PIX_W-1:0]      i_pixel_row,
    // Result output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CNT_W-1:0]      o_escape_count,
    output logic [COLOUR_W-1:0]   o_pixel_colour,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_dp_ctrl w_ctrl;
    logic     w_bail;

    // Configuration registers; each takes the low bits of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sine      <= RST_SINE;
            r_cfg.cosine    <= RST_COSINE;
            r_cfg.step_re   <= RST_STEP_RE;
            r_cfg.step_im   <= RST_STEP_IM;
            r_cfg.origin_re <= RST_ORIGIN_RE;
            r_cfg.origin_im <= RST_ORIGIN_IM;
            r_cfg.limit     <= RST_LIMIT;
            r_cfg.mode      <= RST_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROTATE_SINE:     r_cfg.sine      <= i_cfg_data[TRIG_W-1:0];
                CFG_ROTATE_COSINE:   r_cfg.cosine    <= i_cfg_data[TRIG_W-1:0];
                CFG_STEP_REAL:       r_cfg.step_re   <= i_cfg_data[Q_W-1:0];
                CFG_STEP_IMAG:       r_cfg.step_im   <= i_cfg_data[Q_W-1:0];
                CFG_ORIGIN_REAL:     r_cfg.origin_re <= i_cfg_data[Q_W-1:0];
                CFG_ORIGIN_IMAG:     r_cfg.origin_im <= i_cfg_data[Q_W-1:0];
                CFG_ITERATION_LIMIT: r_cfg.limit     <= i_cfg_data[CNT_W-1:0];
                CFG_COLOUR_MODE:     r_cfg.mode      <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer owns the handshakes and the output register.
    jetr_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_escape_count (o_escape_count),
        .o_pixel_colour (o_pixel_colour),
        .i_bail         (w_bail),
        .o_ctrl         (w_ctrl)
    );

    // The datapath holds the pixel, rotated point and z, around the shared multiplier.
    jetr_dp u_dp (
        .i_clk          (i_clk),
        .i_ctrl         (w_ctrl),
        .i_cfg          (r_cfg),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .o_bail         (w_bail)
    );

    // An accepted pixel keeps the core busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("core not busy after accepting a pixel beat");

    // The core only becomes ready again when it hands a result to the output register.
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("core became ready without presenting a result");

    // The reported count never exceeds the iteration limit.
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_escape_count <= r_cfg.limit))
        else $error("escape count exceeds the iteration limit");

endmodule

/* tb/sv/julia_escape_time_rotated_core_tb.sv */
// Self-checking testbench for julia_escape_time_rotated_core: rotation, plane mapping,
// escape-time iteration and color lane placement, checked beat by beat against a predictor.
// Depends on jetr_pkg and the core RTL only.
module julia_escape_time_rotated_core_tb;
    import jetr_pkg::*;

    localparam int CLK_HALF          = 6;
    localparam int RESET_CYCLES      = 3;
    localparam int DRAIN_CYCLES      = 16;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int RANDOM_PHASES     = 8;
    localparam int PIXELS_PER_PHASE  = 180;
    localparam int FULL_LIMIT_PHASE  = 2;
    localparam int DEEP_LIMIT_PHASE  = 6;
    localparam int WILD_PHASE        = 5;
    localparam int REPORT_CAP        = 100;

    // Arithmetic of the unit, in the terms of its own fixed-point formats.
    localparam longint HALF_COLS     = 512;
    localparam longint HALF_ROWS     = 384;
    localparam longint TRIG_ONE      = 16384;
    localparam longint JULIA_C       = 123077657;           // 0.4585 in Q4.28
    localparam longint Q28_HIGHEST   = 64'sd2147483647;
    localparam longint Q28_LOWEST    = -64'sd2147483648;
    localparam logic [63:0] BAILOUT_Q56 = 64'd563489559 << 28;
    localparam int unsigned COLOR_STEP = 20;

    typedef struct packed {
        logic [PIX_W-1:0]    col;
        logic [PIX_W-1:0]    row;
        logic [CNT_W-1:0]    count;
        logic [COLOUR_W-1:0] colour;
    } pixel_result_t;

    // One complete register setting of the core.
    typedef struct packed {
        logic [15:0] sine;
        logic [15:0] cosine;
        logic [31:0] step_re;
        logic [31:0] step_im;
        logic [31:0] org_re;
        logic [31:0] org_im;
        logic [7:0]  limit;
        logic [1:0]  mode;
    } view_t;

    class julia_scoreboard;
        longint rot_sine, rot_cosine, step_re, step_im, org_re, org_im;
        int unsigned iter_limit;
        logic [MODE_W-1:0] lane_mode;
        pixel_result_t awaited_pixels[$];
        int unsigned mismatches, compared, pixels_noted, limit_hits, deepest;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROTATE_SINE:     rot_sine   = longint'($signed(data[15:0]));
                CFG_ROTATE_COSINE:   rot_cosine = longint'($signed(data[15:0]));
                CFG_STEP_REAL:       step_re    = longint'($signed(data));
                CFG_STEP_IMAG:       step_im    = longint'($signed(data));
                CFG_ORIGIN_REAL:     org_re     = longint'($signed(data));
                CFG_ORIGIN_IMAG:     org_im     = longint'($signed(data));
                CFG_ITERATION_LIMIT: iter_limit = data[7:0];
                CFG_COLOUR_MODE:     lane_mode  = data[1:0];
                default: ;
            endcase
        endfunction

        function void take_view(view_t v);
            write_reg(CFG_ROTATE_SINE, {16'd0, v.sine});
            write_reg(CFG_ROTATE_COSINE, {16'd0, v.cosine});
            write_reg(CFG_STEP_REAL, v.step_re);
            write_reg(CFG_STEP_IMAG, v.step_im);
            write_reg(CFG_ORIGIN_REAL, v.org_re);
            write_reg(CFG_ORIGIN_IMAG, v.org_im);
            write_reg(CFG_ITERATION_LIMIT, {24'd0, v.limit});
            write_reg(CFG_COLOUR_MODE, {30'd0, v.mode});
        endfunction

        static function longint clamp_q28(longint v);
            if (v > Q28_HIGHEST) return Q28_HIGHEST;
            if (v < Q28_LOWEST) return Q28_LOWEST;
            return v;
        endfunction

        // Rotate, map and iterate one pixel; returns its count and color word.
        function pixel_result_t escape_time(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
            longint dx, dy, rx, ry, zr, zi, sq_re, sq_im, next_re, next_im;
            logic [63:0] mag2;
            int unsigned n, lane_shift;
            pixel_result_t r;
            dx = longint'(col) - HALF_COLS;
            dy = longint'(row) - HALF_ROWS;
            // Division on signed operands truncates toward zero, as the core must.
            rx = (dx * rot_cosine - dy * rot_sine) / TRIG_ONE + HALF_COLS;
            ry = (dx * rot_sine + dy * rot_cosine + HALF_ROWS * TRIG_ONE) / TRIG_ONE;
            zr = clamp_q28(rx * step_re + org_re);
            zi = clamp_q28(ry * step_im + org_im);
            n = 0;
            while (n < iter_limit) begin
                sq_re = zr * zr;
                sq_im = zi * zi;
                mag2 = sq_re + sq_im;
                if (mag2 >= BAILOUT_Q56) break;
                next_re = clamp_q28(((sq_re - sq_im) >>> 28) + JULIA_C);
                next_im = clamp_q28(((zr * zi) >>> 27) + JULIA_C);
                zr = next_re;
                zi = next_im;
                n++;
            end
            case (lane_mode)
                MODE_BLUE:  lane_shift = 0;
                MODE_GREEN: lane_shift = 8;
                default:    lane_shift = 16;   // red, and the spare code behaves as red
            endcase
            r.col = col;
            r.row = row;
            r.count = n[CNT_W-1:0];
            r.colour = 32'((n * COLOR_STEP) << lane_shift);
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
            pixel_result_t r;
            r = escape_time(col, row);
            awaited_pixels.push_back(r);
            pixels_noted++;
            if (iter_limit != 0 && r.count == iter_limit) limit_hits++;
            if (r.count > deepest) deepest = r.count;
        endfunction

        function int unsigned pending();
            return awaited_pixels.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP) $display("mismatch: %s", msg);
        endtask

        task check_result(logic [CNT_W-1:0] count, logic [COLOUR_W-1:0] colour);
            pixel_result_t want;
            if (awaited_pixels.size() == 0) begin
                report_mismatch($sformatf("result beat (count %0d, color %h) with no pixel outstanding",
                                          count, colour));
                return;
            end
            want = awaited_pixels.pop_front();
            compared++;
            if (count !== want.count)
                report_mismatch($sformatf("pixel (%0d,%0d) escape_count %0d, expected %0d",
                                          want.col, want.row, count, want.count));
            if (colour !== want.colour)
                report_mismatch($sformatf("pixel (%0d,%0d) pixel_colour %h, expected %h",
                                          want.col, want.row, colour, want.colour));
        endtask

        task close_out();
            if (awaited_pixels.size() != 0)
                report_mismatch($sformatf("%0d pixels never produced a result",
                                          awaited_pixels.size()));
        endtask
    endclass

    // Stimulus side of the core. Every input starts at a known value.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [PIX_W-1:0]      i_pixel_column = '0;
    logic [PIX_W-1:0]      i_pixel_row = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    wire                   o_in_stall;
    wire                   o_out_valid;
    wire [CNT_W-1:0]       o_escape_count;
    wire [COLOUR_W-1:0]    o_pixel_colour;

    julia_scoreboard pixel_board = new;

    // Pacing knobs: chance in a hundred that the sender idles or the receiver stalls
    // in a given cycle. They change per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;
    int unsigned settings_loaded = 0;

    julia_escape_time_rotated_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_escape_count (o_escape_count),
        .o_pixel_colour (o_pixel_colour),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Result side. Values read right after the rising edge are the ones the core saw at
    // that edge, since its own updates land later in the same time step. A result beat
    // is taken when valid is high and our stall was low. The stall for the next cycle
    // is drawn here too, and the watchdog counts cycles in which no beat moves on
    // either channel.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                pixel_board.check_result(o_escape_count, o_pixel_colour);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one pixel beat, after an optional run of idle cycles, and hold it until the
    // core takes it. Valid is only lowered when an idle cycle really follows, so a
    // back-to-back beat keeps valid high without a second assignment in that step.
    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_column <= col;
        i_pixel_row <= row;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pixel_board.note_pixel(col, row);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        pixel_board.write_reg(idx, data);
    endtask

    // Write all eight registers back to back. Narrow registers get random upper bits
    // in the data word, which the core has to drop.
    task automatic load_view(input view_t v);
        write_cfg(CFG_ROTATE_SINE, {16'($urandom), v.sine});
        write_cfg(CFG_ROTATE_COSINE, {16'($urandom), v.cosine});
        write_cfg(CFG_STEP_REAL, v.step_re);
        write_cfg(CFG_STEP_IMAG, v.step_im);
        write_cfg(CFG_ORIGIN_REAL, v.org_re);
        write_cfg(CFG_ORIGIN_IMAG, v.org_im);
        write_cfg(CFG_ITERATION_LIMIT, {24'($urandom), v.limit});
        write_cfg(CFG_COLOUR_MODE, {30'($urandom), v.mode});
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Registers are only touched once every result is back and the core has settled.
    task automatic drain_results();
        while (pixel_board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic view_t reset_view();
        view_t v;
        v.sine = 16'd0;
        v.cosine = 16'd16384;
        v.step_re = 32'd524801;
        v.step_im = 32'd699962;
        v.org_re = -32'sd242405806;
        v.org_im = 32'd44800267;
        v.limit = 8'd200;
        v.mode = MODE_BLUE;
        return v;
    endfunction

    // Most phases frame a sensible window around the Julia set with random sine, cosine
    // and zoom; the wild phase throws arbitrary steps and origins that mostly saturate.
    function automatic view_t random_view(int unsigned phase);
        view_t v;
        longint pitch, pitch_im, centre_re, centre_im;
        v.sine = 16'($urandom_range(0, 32768)) - 16'd16384;
        v.cosine = 16'($urandom_range(0, 32768)) - 16'd16384;
        if (phase == WILD_PHASE) begin
            v.step_re = $urandom;
            v.step_im = $urandom;
            v.org_re = $urandom;
            v.org_im = $urandom;
        end else begin
            pitch = $urandom_range(1 << 17, 1 << 21);
            if ($urandom_range(7) == 0) pitch = -pitch;
            pitch_im = pitch * 4 / 3;
            centre_re = longint'($urandom_range(0, 1 << 28)) - (1 << 27);
            centre_im = longint'($urandom_range(0, 1 << 28)) - (1 << 27);
            v.step_re = 32'(pitch);
            v.step_im = 32'(pitch_im);
            v.org_re = 32'(centre_re - pitch * HALF_COLS);
            v.org_im = 32'(centre_im - pitch_im * HALF_ROWS);
        end
        if (phase == FULL_LIMIT_PHASE)
            v.limit = 8'd255;
        else if (phase == DEEP_LIMIT_PHASE)
            v.limit = 8'($urandom_range(1, 255));
        else
            v.limit = 8'($urandom_range(1, 48));
        v.mode = 2'($urandom_range(0, 3));
        return v;
    endfunction

    initial begin : stimulus
        view_t v;
        int unsigned phase, k;
        logic [PIX_W-1:0] col, row;
        pixel_board.take_view(reset_view());
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reset values first: frame corners, the center and the rows
        // beyond the nominal frame height.
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd767);
        send_pixel(10'd512, 10'd384);
        send_pixel(10'd511, 10'd383);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        i_in_valid <= 1'b0;

        // Quarter turn, full iteration limit, green lane: long runs whose count*20
        // spills past the byte.
        drain_results();
        v = reset_view();
        v.sine = 16'd16384;
        v.cosine = 16'd0;
        v.limit = 8'd255;
        v.mode = MODE_GREEN;
        load_view(v);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd767);
        send_pixel(10'd300, 10'd600);
        send_pixel(10'd700, 10'd100);
        i_in_valid <= 1'b0;

        // Negative sine and cosine, so the rotated products truncate toward zero from
        // below; a single iteration allowed, red lane.
        drain_results();
        v = reset_view();
        v.sine = -16'sd11585;
        v.cosine = -16'sd11585;
        v.limit = 8'd1;
        v.mode = MODE_RED;
        load_view(v);
        send_pixel(10'd0, 10'd767);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd513, 10'd385);
        i_in_valid <= 1'b0;

        // Zero iteration limit with the spare lane code.
        drain_results();
        v = reset_view();
        v.sine = 16'd16384;
        v.cosine = -16'sd16384;
        v.limit = 8'd0;
        v.mode = 2'd3;
        load_view(v);
        send_pixel(10'd5, 10'd5);
        send_pixel(10'd1000, 10'd700);
        i_in_valid <= 1'b0;

        // Extreme steps and origins: the mapped point saturates high and low.
        drain_results();
        v.sine = -16'sd16384;
        v.cosine = 16'd16384;
        v.step_re = 32'h7FFF_FFFF;
        v.step_im = 32'h8000_0000;
        v.org_re = 32'h8000_0000;
        v.org_im = 32'h7FFF_FFFF;
        v.limit = 8'd255;
        load_view(v);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd384);
        send_pixel(10'd100, 10'd700);
        i_in_valid <= 1'b0;

        // Default window at the full limit with the spare lane code: counts near the
        // set push count*20 past the red byte.
        drain_results();
        v = reset_view();
        v.limit = 8'd255;
        v.mode = 2'd3;
        load_view(v);
        send_pixel(10'd512, 10'd384);
        send_pixel(10'd520, 10'd390);
        i_in_valid <= 1'b0;

        // Random part. Pacing cycles through: none, sender idling, receiver stalling, both.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            load_view(random_view(phase));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (k = 0; k < PIXELS_PER_PHASE; k++) begin
                col = 10'($urandom_range(0, 1023));
                if ($urandom_range(15) == 0)
                    row = 10'($urandom_range(768, 1023));
                else
                    row = 10'($urandom_range(0, 767));
                send_pixel(col, row);
            end
            i_in_valid <= 1'b0;
        end

        drain_results();
        pixel_board.close_out();
        $display("run covered %0d pixel beats under %0d register settings and four pacing patterns",
                 pixel_board.pixels_noted, settings_loaded);
        $display("%0d results compared, %0d ran into the iteration limit, deepest count %0d",
                 pixel_board.compared, pixel_board.limit_hits, pixel_board.deepest);
        if (pixel_board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
